@@ rtl/afct_pkg.sv @@
// Shared types and constants for the aging fault-code table.
`default_nettype none

package afct_pkg;

  localparam int TABLES    = 3;
  localparam int SLOTS_DEF = 15;
  localparam int CODE_W    = 16;
  localparam int LIFE_W    = 4;
  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int OCW       = $clog2(OUT_DEPTH + 1);

  localparam logic [LIFE_W-1:0] LIFE_RESET = 4'd12;
  localparam logic [3:0]        LC_MAX     = 4'd15;

  localparam logic ACT_REPORT = 1'b0;
  localparam logic ACT_TICK   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [1:0]        table_sel;
    logic [CODE_W-1:0] code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        out_table;
    logic [3:0]        out_slot;
    logic [CODE_W-1:0] out_code;
    logic [3:0]        live_count;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic              tick;
    logic [1:0]        tbl;
    logic [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LIFE_W-1:0] life;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/afct_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module afct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/afct_fifo.sv @@
// Small register-based queue with occupancy count.
`default_nettype none

module afct_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [W-1:0]  wdata,
  output logic               full,
  input  wire logic          pop,
  output logic      [W-1:0]  rdata,
  output logic               empty,
  output logic      [CW-1:0] count
);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

@@ rtl/afct_front.sv @@
// Front end: accepts requests, drops reports to a nonexistent table, queues commands.
`default_nettype none

module afct_front import afct_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t item,
  input  wire logic     push,
  output logic          full,
  output cmd_t          cmd,
  output logic          cmd_valid,
  input  wire logic     cmd_ready
);

  localparam int CMD_W = $bits(cmd_t);

  cmd_t             cmd_in;
  logic             keep;
  logic             q_empty;
  logic [CMD_W-1:0] q_rdata;
  logic [$clog2(CMD_DEPTH + 1)-1:0] q_count;

  // Ticks always go through; a report needs a real table.
  assign keep        = (item.action == ACT_TICK) || (item.table_sel < 2'(TABLES));
  assign cmd_in.tick = (item.action == ACT_TICK);
  assign cmd_in.tbl  = item.table_sel;
  assign cmd_in.code = item.code;

  afct_fifo #(
    .W     (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_ready),
    .rdata (q_rdata),
    .empty (q_empty),
    .count (q_count)
  );

  assign cmd       = cmd_t'(q_rdata);
  assign cmd_valid = !q_empty && (q_count != '0);

endmodule

`default_nettype wire

@@ rtl/afct_back.sv @@
// Back end: slot storage, compaction/refresh/placement and the aging dump.
`default_nettype none

module afct_back import afct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire logic [LIFE_W-1:0] refresh,
  input  wire logic [OCW-1:0]    out_count,
  output out_item_t              res,
  output logic                   res_push
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int DEPTH = TABLES * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int EW    = $bits(entry_t);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_COMPACT  = 6'b000010,
    ST_DRAIN    = 6'b000100,
    ST_PLACE    = 6'b001000,
    ST_DUMP     = 6'b010000,
    ST_DUMP_END = 6'b100000
  } state_t;

  state_t            state;
  logic [1:0]        tb;
  logic [CODE_W-1:0] code_c;
  logic [SW-1:0]     rd;
  logic [CW-1:0]     wr;
  logic              pend_v;
  logic [SW-1:0]     pend_wr;
  logic              found;
  logic [SW-1:0]     found_idx;
  logic [1:0]        dt;
  logic [SW-1:0]     di;
  logic              b_v;
  logic [1:0]        b_t;
  logic [SW-1:0]     b_i;
  logic [3:0]        snap;

  logic [TABLES-1:0][SLOTS-1:0] live;
  logic [TABLES-1:0][CW-1:0]    counts;

  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;
  logic [EW-1:0]     ram_q;
  entry_t            rdata;

  logic              rd_live;
  logic              hit;
  logic              credit;
  logic [CW-1:0]     cnt_t;
  logic              can_place;
  logic [SLOTS-1:0]  live_place;
  logic [CW-1:0]     count_place;
  logic              b_live;
  logic [LIFE_W-1:0] b_life_dec;
  logic [3:0]        lc_now;

  function automatic logic [AW-1:0] slot_addr(logic [1:0] t, logic [SW-1:0] s);
    return AW'(t) * AW'(SLOTS) + AW'(s);
  endfunction

  function automatic logic [SLOTS-1:0] low_mask(logic [CW-1:0] c);
    logic [SLOTS-1:0] m;
    for (int j = 0; j < SLOTS; j++) begin
      m[j] = (CW'(j) < c);
    end
    return m;
  endfunction

  function automatic logic [3:0] sat_count(logic [CW-1:0] c);
    if (8'(c) > 8'(LC_MAX)) begin
      return LC_MAX;
    end
    return 4'(c);
  endfunction

  afct_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign rdata      = entry_t'(ram_q);
  assign cmd_ready  = (state == ST_IDLE);
  assign rd_live    = live[tb][rd];
  assign hit        = pend_v && (code_c != '0) && (rdata.code == code_c);
  assign credit     = ((OCW+1)'(out_count) + (OCW+1)'(b_v)) < (OCW+1)'(OUT_DEPTH);
  assign cnt_t      = counts[tb];
  assign can_place  = (code_c != '0) && !found && (cnt_t < CW'(SLOTS)) && (refresh != '0);
  assign b_live     = live[b_t][b_i];
  assign b_life_dec = rdata.life - 1'b1;
  assign lc_now     = sat_count(counts[b_t]);

  // Layout after a report: live slots first; zero refresh frees a match.
  always_comb begin
    live_place  = low_mask(cnt_t);
    count_place = cnt_t;
    if (found && (refresh == '0)) begin
      live_place[found_idx] = 1'b0;
      count_place           = cnt_t - 1'b1;
    end else if (can_place) begin
      live_place[cnt_t[SW-1:0]] = 1'b1;
      count_place               = cnt_t + 1'b1;
    end
  end

  always_comb begin
    re       = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = rdata;
    res_push = 1'b0;
    res      = '0;
    case (state)
      ST_COMPACT: begin
        if (rd_live) begin
          re    = 1'b1;
          raddr = slot_addr(tb, rd);
        end
      end
      ST_DUMP: begin
        if (credit) begin
          re    = 1'b1;
          raddr = slot_addr(dt, di);
        end
      end
      default: begin
      end
    endcase

    // Compaction write-back; a matching code gets its lifetime refreshed.
    if (pend_v) begin
      we         = 1'b1;
      waddr      = slot_addr(tb, pend_wr);
      wdata.code = rdata.code;
      wdata.life = hit ? refresh : rdata.life;
    end

    if ((state == ST_PLACE) && can_place) begin
      we         = 1'b1;
      waddr      = slot_addr(tb, cnt_t[SW-1:0]);
      wdata.code = code_c;
      wdata.life = refresh;
    end

    // Dump one slot and age it.
    if (b_v) begin
      res_push       = 1'b1;
      res.out_table  = b_t;
      res.out_slot   = 4'(b_i);
      res.out_code   = b_live ? rdata.code : '0;
      res.live_count = (b_i == '0) ? lc_now : snap;
      res.last       = (b_t == 2'(TABLES - 1)) && (b_i == SW'(SLOTS - 1));
      if (b_live) begin
        we         = 1'b1;
        waddr      = slot_addr(b_t, b_i);
        wdata.code = rdata.code;
        wdata.life = b_life_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd     <= '0;
      wr     <= '0;
      dt     <= '0;
      di     <= '0;
      pend_v <= 1'b0;
      b_v    <= 1'b0;
      found  <= 1'b0;
      live   <= '0;
      counts <= '0;
    end else begin
      pend_v <= 1'b0;
      b_v    <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            tb     <= cmd.tbl;
            code_c <= cmd.code;
            found  <= 1'b0;
            rd     <= '0;
            wr     <= '0;
            dt     <= '0;
            di     <= '0;
            state  <= cmd.tick ? ST_DUMP : ST_COMPACT;
          end
        end
        ST_COMPACT: begin
          if (rd_live) begin
            pend_v  <= 1'b1;
            pend_wr <= wr[SW-1:0];
            wr      <= wr + 1'b1;
          end
          if (rd == SW'(SLOTS - 1)) begin
            state <= ST_DRAIN;
          end else begin
            rd <= rd + 1'b1;
          end
        end
        ST_DRAIN: begin
          state <= ST_PLACE;
        end
        ST_PLACE: begin
          live[tb]   <= live_place;
          counts[tb] <= count_place;
          state      <= ST_IDLE;
        end
        ST_DUMP: begin
          if (credit) begin
            b_v <= 1'b1;
            b_t <= dt;
            b_i <= di;
            if (di == SW'(SLOTS - 1)) begin
              di <= '0;
              if (dt == 2'(TABLES - 1)) begin
                state <= ST_DUMP_END;
              end else begin
                dt <= dt + 1'b1;
              end
            end else begin
              di <= di + 1'b1;
            end
          end
        end
        ST_DUMP_END: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (hit) begin
        found     <= 1'b1;
        found_idx <= pend_wr;
      end

      if (b_v) begin
        if (b_i == '0) begin
          snap <= lc_now;
        end
        if (b_live && (b_life_dec == '0)) begin
          live[b_t][b_i] <= 1'b0;
          counts[b_t]    <= counts[b_t] - 1'b1;
        end
      end
    end
  end

  a_count_matches_live: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |->
      ($countones(live[0]) == counts[0]) && ($countones(live[1]) == counts[1]) &&
      ($countones(live[2]) == counts[2]))
    else $error("live count out of step with live bits");

  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (out_count < OCW'(OUT_DEPTH)))
    else $error("result pushed into a full queue");

  a_writeback_from_compact: assert property (@(posedge clk) disable iff (rst)
    pend_v |-> $past(state) == ST_COMPACT)
    else $error("compaction write-back outside compaction");

  a_compact_keeps_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_PLACE |-> wr == counts[tb])
    else $error("compaction moved a different number of slots than are live");

endmodule

`default_nettype wire

@@ rtl/aging_fault_code_table.sv @@
// Aging fault-code table: three tables of SLOTS code/lifetime slots.
//
// Input queue: drive item and push; a request is taken at a clock edge with push high
// and full low. action = report puts code into table table_sel (compacting that
// table first; code zero only compacts; table three is ignored). action = tick
// dumps every slot of every table and ages it by one.
// Result queue: while empty is low the oldest result sits on result; pop takes it.
// A tick yields 3*SLOTS results, table-major, with last set on the final one.
// Configuration: cfg_data is the refresh lifetime, written on cfg_valid with
// cfg_ready (always high); write it only while the block is idle.
// Timing: one request at a time in the back end. A report makes one pass over
// the table through the slot RAM, then a write-back stage and a placement step.
// A tick reads one slot per cycle through the RAM's registered read when the
// receiver pops every cycle; the first result then passes through the registered
// read into the result queue. A two-entry command queue lets new requests in
// while the back end works; a four-entry result queue absorbs stalls.
// When the receiver stalls, the dump holds and the command queue fills up.
// Reset: all slots read as empty (live bits cleared), refresh lifetime is 12.
`default_nettype none

module aging_fault_code_table import afct_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire in_item_t          item,
  input  wire logic              push,
  output logic                   full,
  output out_item_t              result,
  output logic                   empty,
  input  wire logic              pop,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [LIFE_W-1:0] cfg_data
);

  localparam int RES_W = $bits(out_item_t);

  cmd_t              cmd;
  logic              cmd_valid;
  logic              cmd_ready;
  logic [LIFE_W-1:0] refresh_lifetime;
  out_item_t         res;
  logic              res_push;
  logic              out_full;
  logic [OCW-1:0]    out_count;
  logic [RES_W-1:0]  out_q;

  // Refresh lifetime register; always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_lifetime <= LIFE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      refresh_lifetime <= cfg_data;
    end
  end

  // Accept and classify requests.
  afct_front u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .full      (full),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  // Carry out reports and ticks against the slot storage.
  afct_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .refresh   (refresh_lifetime),
    .out_count (out_count),
    .res       (res),
    .res_push  (res_push)
  );

  // Hold results until the receiver pops them; the back end only issues a
  // slot read when a place is reserved here.
  afct_fifo #(
    .W     (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_q),
    .empty (empty),
    .count (out_count)
  );

  assign result = out_item_t'(out_q);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !out_full)
    else $error("result queue overflow");

endmodule

`default_nettype wire

@@ dv/tb_aging_fault_code_table.sv @@
// Self-checking testbench for the aging fault-code table: directed and random requests.
`default_nettype none

module tb_aging_fault_code_table;
  import afct_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  // A report makes no result, so after the last dump the back end may still be
  // busy with queued reports: hold off long enough for a full command queue.
  localparam int SETTLE_CYC = (CMD_DEPTH + 1) * (SLOTS + 3) + 8;
  localparam int TAIL_CYC   = TABLES * SLOTS + 8;
  localparam int IDLE_LIMIT = 4000;
  localparam int POOL_N     = 6;

  logic                  clk;
  logic                  rst;
  in_item_t              item;
  logic                  push;
  logic                  full;
  out_item_t             result;
  logic                  empty;
  logic                  pop;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LIFE_W-1:0]     cfg_data;

  aging_fault_code_table #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .push      (push),
    .full      (full),
    .result    (result),
    .empty     (empty),
    .pop       (pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Predicted table contents and the lifetime register.
  logic [CODE_W-1:0] code_tbl[TABLES][SLOTS];
  logic [LIFE_W-1:0] life_tbl[TABLES][SLOTS];
  logic [LIFE_W-1:0] refresh_life;

  // Expected dump results, oldest first.
  out_item_t         pending_dump[$];
  out_item_t         want;
  logic [CODE_W-1:0] code_pool[TABLES][POOL_N];

  int                n_fail;
  int                burst_left;
  int unsigned       rx_phase_left;
  int unsigned       rx_wait;
  bit                rx_free;
  int                idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Move live slots to the front in order, clear the rest.
  function automatic void compact_tbl(int t);
    int wr;
    wr = 0;
    for (int rd = 0; rd < SLOTS; rd++) begin
      if (life_tbl[t][rd] != '0) begin
        code_tbl[t][wr] = code_tbl[t][rd];
        life_tbl[t][wr] = life_tbl[t][rd];
        wr++;
      end
    end
    for (; wr < SLOTS; wr++) begin
      code_tbl[t][wr] = '0;
      life_tbl[t][wr] = '0;
    end
  endfunction

  // Compact, then refresh a matching live slot or take the first free one.
  // Drop the code when the table is full.
  function automatic void file_report(int t, logic [CODE_W-1:0] c);
    compact_tbl(t);
    if (c == '0) return;
    for (int i = 0; i < SLOTS; i++) begin
      if (life_tbl[t][i] != '0) begin
        if (code_tbl[t][i] == c) begin
          life_tbl[t][i] = refresh_life;
          return;
        end
      end else begin
        code_tbl[t][i] = c;
        life_tbl[t][i] = refresh_life;
        return;
      end
    end
  endfunction

  // Queue one result per slot, table-major, then age every live slot.
  function automatic void dump_and_age();
    out_item_t r;
    int        cnt;
    for (int t = 0; t < TABLES; t++) begin
      cnt = 0;
      for (int i = 0; i < SLOTS; i++)
        if (life_tbl[t][i] != '0) cnt++;
      if (cnt > 15) cnt = 15;
      for (int i = 0; i < SLOTS; i++) begin
        r.out_table  = 2'(t);
        r.out_slot   = 4'(i);
        r.out_code   = (life_tbl[t][i] != '0) ? code_tbl[t][i] : '0;
        r.live_count = 4'(cnt);
        r.last       = (t == TABLES - 1) && (i == SLOTS - 1);
        if (life_tbl[t][i] != '0) life_tbl[t][i] = life_tbl[t][i] - 1'b1;
        pending_dump.push_back(r);
      end
    end
  endfunction

  function automatic void predict_request(in_item_t req);
    if (req.action == ACT_TICK)
      dump_and_age();
    else if (int'(req.table_sel) < TABLES)
      file_report(int'(req.table_sel), req.code);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Send one request. Push stays high across back-to-back requests of a burst;
  // drop it only for a gap between bursts.
  task automatic send_request(input in_item_t req);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then run a long burst with no idling at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
    end
    item <= req;
    push <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    predict_request(req);
    burst_left--;
  endtask

  task automatic send_fields(input logic act, input logic [1:0] tsel,
                             input logic [CODE_W-1:0] c);
    in_item_t req;
    req.action    = act;
    req.table_sel = tsel;
    req.code      = c;
    send_request(req);
  endtask

  // Stop sending, wait for every expected result, then let queued reports finish.
  task automatic wait_idle();
    push <= 1'b0;
    burst_left = 0;
    while (pending_dump.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [LIFE_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    refresh_life = v;
    cfg_valid <= 1'b0;
  endtask

  // Mostly reports from a small pool per table so codes repeat and get
  // refreshed; some ticks; a little noise (ignored table, compact only).
  function automatic in_item_t pick_request();
    in_item_t req;
    int       roll;
    roll          = $urandom_range(0, 99);
    req.action    = ACT_REPORT;
    req.table_sel = 2'($urandom_range(0, 2));
    req.code      = ($urandom_range(0, 2) != 0) ?
                    code_pool[req.table_sel][$urandom_range(0, POOL_N - 1)] :
                    16'($urandom);
    if (roll < 15) begin
      req.action    = ACT_TICK;
      req.table_sel = 2'($urandom_range(0, 3));
      req.code      = 16'($urandom);
    end else if (roll < 19) begin
      req.table_sel = 2'd3;
    end else if (roll < 24) begin
      req.code = '0;
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Dump straight out of reset: every slot empty, counts zero.
  task automatic test_empty_dump();
    send_fields(ACT_TICK, 2'd0, '0);
  endtask

  // One code per table, an ignored table three, a duplicate, a bare compact and a dump.
  task automatic test_report_each_table();
    send_fields(ACT_REPORT, 2'd0, 16'h0001);
    send_fields(ACT_REPORT, 2'd1, 16'hFFFF);
    send_fields(ACT_REPORT, 2'd2, 16'h8000);
    send_fields(ACT_REPORT, 2'd3, 16'h5A5A);
    send_fields(ACT_REPORT, 2'd0, 16'h0001);
    send_fields(ACT_REPORT, 2'd1, 16'h0000);
    send_fields(ACT_TICK,   2'd3, 16'hA5A5);
  endtask

  // Fill table zero past its last slot; the extra code is dropped.
  task automatic test_table_overflow();
    for (int i = 0; i < SLOTS; i++)
      send_fields(ACT_REPORT, 2'd0, 16'h0100 + 16'(i));
    send_fields(ACT_TICK, 2'd0, '0);
  endtask

  // With lifetime zero a reported code is never placed or live.
  task automatic test_zero_lifetime();
    wait_idle();
    write_lifetime(4'd0);
    send_fields(ACT_REPORT, 2'd2, 16'h0042);
    send_fields(ACT_TICK, 2'd2, '0);
  endtask

  // Random traffic in phases, each with its own lifetime setting.
  task automatic test_random_traffic();
    logic [LIFE_W-1:0] lives[5];
    in_item_t          req;
    int                sent;
    lives = '{4'd15, 4'd1, 4'd0, 4'd3, 4'($urandom_range(2, 14))};
    foreach (lives[p]) begin
      wait_idle();
      write_lifetime(lives[p]);
      sent = 0;
      while (sent < 20) begin
        req = pick_request();
        send_request(req);
        // Reports for table three are ignored and do not count.
        if (req.action == ACT_TICK || req.table_sel != 2'd3) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       <= 1'b1;
    push      <= 1'b0;
    item      <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    n_fail     = 0;
    burst_left = 0;
    refresh_life = LIFE_RESET;
    for (int t = 0; t < TABLES; t++) begin
      for (int i = 0; i < SLOTS; i++) begin
        code_tbl[t][i] = '0;
        life_tbl[t][i] = '0;
      end
      for (int k = 0; k < POOL_N; k++)
        code_pool[t][k] = 16'($urandom_range(1, 16'hFFFF));
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_dump();
    test_report_each_table();
    test_table_overflow();
    test_zero_lifetime();
    test_random_traffic();

    // Drain, then hold a little longer to catch stray results.
    push <= 1'b0;
    while (pending_dump.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
    if (n_fail == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: alternate free-running phases with phases of random stalls.
  // ---------------------------------------------------------------------------

  initial begin
    pop           <= 1'b0;
    rx_phase_left  = 0;
    rx_wait        = 0;
    rx_free        = 1'b1;
  end

  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_free       = ($urandom_range(0, 2) == 0);
      rx_phase_left = $urandom_range(20, 120);
    end
    rx_phase_left--;
    if (rx_free) begin
      pop <= 1'b1;
    end else if (rx_wait == 0) begin
      pop <= 1'b1;
      rx_wait = $urandom_range(0, 12);
    end else begin
      pop <= 1'b0;
      rx_wait--;
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: compare each popped result with the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst && pop === 1'b1 && empty === 1'b0) begin
      if (pending_dump.size() == 0) begin
        $error("result with nothing pending: table %0d slot %0d code %h",
               result.out_table, result.out_slot, result.out_code);
        n_fail++;
      end else begin
        want = pending_dump.pop_front();
        if (result.out_table !== want.out_table) begin
          $error("out_table: expected %0d, got %0d", want.out_table, result.out_table);
          n_fail++;
        end
        if (result.out_slot !== want.out_slot) begin
          $error("out_slot: expected %0d, got %0d", want.out_slot, result.out_slot);
          n_fail++;
        end
        if (result.out_code !== want.out_code) begin
          $error("out_code: expected %h, got %h", want.out_code, result.out_code);
          n_fail++;
        end
        if (result.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, result.live_count);
          n_fail++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result.last);
          n_fail++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves for too long.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0) ||
                 (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/afct_pkg.sv
rtl/afct_ram.sv
rtl/afct_fifo.sv
rtl/afct_front.sv
rtl/afct_back.sv
rtl/aging_fault_code_table.sv
dv/tb_aging_fault_code_table.sv
